[rtl/core/tts_pkg.sv]
// Shared types, codes and widths for the thread table scheduler.
package tts_pkg;

    // Default table size
    localparam int MAX_THREADS_DEF = 16;

    // Field widths
    localparam int ID_W       = 9;
    localparam int TID_W      = 8;
    localparam int LIFE_W     = 16;
    localparam int PRIO_W     = 8;
    localparam int CMD_W      = 2;
    localparam int POL_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;

    // Policy codes
    localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
    localparam logic [POL_W-1:0] POL_PRIO = 2'd2;
    localparam logic [POL_W-1:0] POL_RR   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_LIFE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_PRIO = 2'd2;

    // Id of the main thread
    localparam logic signed [ID_W-1:0] MAIN_ID = -9'sd1;

    // One table entry
    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [LIFE_W-1:0]      life;
        logic [PRIO_W-1:0]      prio;
    } t_slot;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXIT_RD,
        ST_EXIT_UPD,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

[rtl/core/tts_slot_ram.sv]
// Thread table storage: one write port, one registered read port.
module tts_slot_ram #(
    parameter int DEPTH = tts_pkg::MAX_THREADS_DEF,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  tts_pkg::t_slot  i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output tts_pkg::t_slot  o_rd_data
);

    tts_pkg::t_slot r_mem [DEPTH];
    tts_pkg::t_slot r_rd_data;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read entry into a registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/thread_table_scheduler.sv]
// Thread scheduler top level: command sequencer, table scan and result register.
//
// Thread table scheduler. Slot 0 is the main thread (id -1); create items append
// threads in creation order, tick items pick the next thread under the policy
// register (FIFO, shortest job, priority, round robin) and exit items retire or
// age the running thread. Every item yields one result beat. Entries live in a
// one-read-port table with a registered read port; a tick scans it one entry per
// cycle, and an exit under round robin or priority reads the running entry and
// writes it back through the exit read and update states. A finished result
// waits in the output register while the next item is taken. No clearing pass
// runs after reset; config writes are taken at once.
module thread_table_scheduler #(
    parameter int MAX_THREADS = tts_pkg::MAX_THREADS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Item input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [tts_pkg::CMD_W-1:0]            i_cmd,
    input  logic [tts_pkg::TID_W-1:0]            i_thread_id,
    input  logic [tts_pkg::LIFE_W-1:0]           i_run_length,
    input  logic [tts_pkg::PRIO_W-1:0]           i_urgency,
    // Result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [tts_pkg::ID_W-1:0]      o_running_id,
    output logic                                 o_switched,
    output logic                                 o_none_ready,
    output logic                                 o_retired,
    output logic                                 o_table_full,
    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int SW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);

    // Configuration
    logic [tts_pkg::POL_W-1:0]  r_policy;
    logic [tts_pkg::LIFE_W-1:0] r_main_life;
    logic [tts_pkg::PRIO_W-1:0] r_main_prio;

    // Scheduler state
    tts_pkg::t_state            r_st, n_st;
    logic [CW-1:0]              r_count;
    logic [SW-1:0]              r_cur;
    logic signed [tts_pkg::ID_W-1:0] r_cur_id;
    logic [MAX_THREADS-1:0]     r_dead;

    // Scan state
    logic [SW-1:0]              r_addr;
    logic [CW-1:0]              r_left;
    logic                       r_chk;
    logic [SW-1:0]              r_chk_addr;
    logic                       r_found;
    logic [SW-1:0]              r_best_addr;
    logic signed [tts_pkg::ID_W-1:0] r_best_id;
    logic [tts_pkg::LIFE_W-1:0] r_best_life;
    logic [tts_pkg::PRIO_W-1:0] r_best_prio;

    // Pending result flags
    logic r_res_switched, r_res_none, r_res_retired, r_res_full;

    // Output register
    logic                       r_out_valid;
    logic signed [tts_pkg::ID_W-1:0] r_out_id;
    logic r_out_switched, r_out_none, r_out_retired, r_out_full;

    // Table port
    logic           mem_wr_en, mem_rd_en;
    logic [SW-1:0]  mem_wr_addr, mem_rd_addr;
    tts_pkg::t_slot mem_wr_data, mem_rd_data;

    logic in_acc, out_free, rr_mode, tbl_full;
    logic [CW-1:0] addr_inc, cur_inc;
    logic [SW-1:0] addr_adv, cur_adv;
    logic signed [tts_pkg::ID_W-1:0] chk_id;
    logic [tts_pkg::LIFE_W-1:0] chk_life, dec_life;
    logic [tts_pkg::PRIO_W-1:0] chk_prio;
    logic chk_live, better, take, scan_done, fin_found;
    logic [SW-1:0] fin_addr, next_slot;
    logic signed [tts_pkg::ID_W-1:0] fin_id;

    tts_slot_ram #(
        .DEPTH (MAX_THREADS),
        .AW    (SW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign rr_mode  = (r_policy == tts_pkg::POL_FIFO) || (r_policy == tts_pkg::POL_RR);
    assign tbl_full = (r_count == CW'(MAX_THREADS));

    // Advance slot indexes in creation order, wrapping at the thread count
    assign addr_inc = CW'(r_addr) + CW'(1);
    assign addr_adv = (addr_inc == r_count) ? '0 : addr_inc[SW-1:0];
    assign cur_inc  = CW'(r_cur) + CW'(1);
    assign cur_adv  = (cur_inc == r_count) ? '0 : cur_inc[SW-1:0];

    // Substitute the main entry for slot 0
    always_comb begin
        if (r_chk_addr == '0) begin
            chk_id   = tts_pkg::MAIN_ID;
            chk_life = r_main_life;
            chk_prio = r_main_prio;
        end else begin
            chk_id   = mem_rd_data.id;
            chk_life = mem_rd_data.life;
            chk_prio = mem_rd_data.prio;
        end
    end

    // Compare the entry that just came back against the best so far
    assign chk_live  = r_chk && !r_dead[r_chk_addr] && (rr_mode || (chk_id != r_cur_id));
    assign better    = !r_found || ((r_policy == tts_pkg::POL_SJF) ?
                                    (chk_life < r_best_life) : (chk_prio > r_best_prio));
    assign take      = chk_live && (rr_mode || better);
    assign fin_found = r_found || take;
    assign fin_addr  = take ? r_chk_addr : r_best_addr;
    assign fin_id    = take ? chk_id : r_best_id;
    assign scan_done = r_chk && ((rr_mode && chk_live) || (r_left == '0));
    assign next_slot = fin_found ? fin_addr : r_cur;
    assign dec_life  = mem_rd_data.life - tts_pkg::LIFE_W'(1);

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            tts_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == tts_pkg::CMD_TICK) begin
                        n_st = (r_count <= CW'(1)) ? tts_pkg::ST_DONE : tts_pkg::ST_SCAN;
                    end else if (i_cmd == tts_pkg::CMD_EXIT && !rr_mode
                                 && r_policy != tts_pkg::POL_SJF && r_cur != '0) begin
                        n_st = tts_pkg::ST_EXIT_RD;
                    end else if (i_cmd == tts_pkg::CMD_EXIT && r_policy == tts_pkg::POL_RR
                                 && r_cur != '0) begin
                        n_st = tts_pkg::ST_EXIT_RD;
                    end else begin
                        n_st = tts_pkg::ST_DONE;
                    end
                end
            end
            tts_pkg::ST_EXIT_RD:  n_st = tts_pkg::ST_EXIT_UPD;
            tts_pkg::ST_EXIT_UPD: n_st = tts_pkg::ST_DONE;
            tts_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_st = tts_pkg::ST_DONE;
                end
            end
            tts_pkg::ST_DONE: begin
                if (out_free) begin
                    n_st = tts_pkg::ST_IDLE;
                end
            end
            default: n_st = tts_pkg::ST_IDLE;
        endcase
    end

    // Table port and handshake controls
    always_comb begin
        o_in_ready  = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_count[SW-1:0];
        mem_wr_data.id   = $signed({1'b0, i_thread_id});
        mem_wr_data.life = i_run_length;
        mem_wr_data.prio = i_urgency;
        case (r_st)
            tts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                mem_wr_en  = i_in_valid && (i_cmd == tts_pkg::CMD_CREATE) && !tbl_full;
            end
            tts_pkg::ST_EXIT_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_cur;
            end
            tts_pkg::ST_EXIT_UPD: begin
                mem_wr_en        = 1'b1;
                mem_wr_addr      = r_cur;
                mem_wr_data.id   = mem_rd_data.id;
                mem_wr_data.life = dec_life;
                mem_wr_data.prio = mem_rd_data.prio;
            end
            tts_pkg::ST_SCAN: begin
                mem_rd_en = (r_left != '0);
            end
            default: ;
        endcase
    end

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= tts_pkg::POL_FIFO;
            r_main_life <= '0;
            r_main_prio <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tts_pkg::CFG_POLICY:    r_policy    <= i_cfg_data[tts_pkg::POL_W-1:0];
                tts_pkg::CFG_MAIN_LIFE: r_main_life <= i_cfg_data;
                tts_pkg::CFG_MAIN_PRIO: r_main_prio <= i_cfg_data[tts_pkg::PRIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state: sequencer, table bookkeeping, scan progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= tts_pkg::ST_IDLE;
            r_count     <= CW'(1);
            r_cur       <= '0;
            r_cur_id    <= tts_pkg::MAIN_ID;
            r_dead      <= '0;
            r_chk       <= 1'b0;
            r_found     <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;

            // Start an item
            if (in_acc) begin
                r_chk   <= 1'b0;
                r_found <= 1'b0;
                if (i_cmd == tts_pkg::CMD_CREATE && !tbl_full) begin
                    r_dead[r_count[SW-1:0]] <= 1'b0;
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd == tts_pkg::CMD_EXIT && (r_policy == tts_pkg::POL_FIFO
                                                   || r_policy == tts_pkg::POL_SJF)) begin
                    r_dead[r_cur] <= 1'b1;
                end
                if (rr_mode) begin
                    r_left <= r_count - CW'(1);
                end else begin
                    r_left <= r_count;
                end
            end

            // Age the running thread and retire it at zero
            if (r_st == tts_pkg::ST_EXIT_UPD && dec_life == '0) begin
                r_dead[r_cur] <= 1'b1;
            end

            // Walk the table one entry a cycle
            if (r_st == tts_pkg::ST_SCAN) begin
                r_chk <= (r_left != '0);
                if (r_left != '0) begin
                    r_left <= r_left - CW'(1);
                end
                r_found <= fin_found;
                if (scan_done) begin
                    r_cur <= next_slot;
                    if (fin_found) begin
                        r_cur_id <= fin_id;
                    end
                end
            end

            // Hold the result until the beat is taken
            if (r_st == tts_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr         <= rr_mode ? cur_adv : '0;
            r_res_switched <= 1'b0;
            r_res_none     <= (i_cmd == tts_pkg::CMD_TICK) && (r_count <= CW'(1));
            r_res_retired  <= (i_cmd == tts_pkg::CMD_EXIT) && (r_policy == tts_pkg::POL_FIFO
                                                              || r_policy == tts_pkg::POL_SJF);
            r_res_full     <= (i_cmd == tts_pkg::CMD_CREATE) && tbl_full;
        end
        if (r_st == tts_pkg::ST_EXIT_UPD) begin
            r_res_retired <= (dec_life == '0);
        end
        if (r_st == tts_pkg::ST_SCAN) begin
            if (r_left != '0) begin
                r_addr     <= addr_adv;
                r_chk_addr <= r_addr;
            end
            if (take) begin
                r_best_addr <= r_chk_addr;
                r_best_id   <= chk_id;
                r_best_life <= chk_life;
                r_best_prio <= chk_prio;
            end
            if (scan_done) begin
                r_res_none <= !fin_found;
                if (rr_mode) begin
                    r_res_switched <= (r_cur != '0) || (next_slot != '0);
                end else begin
                    r_res_switched <= fin_found && (fin_id != r_cur_id);
                end
            end
        end
        if (r_st == tts_pkg::ST_DONE && out_free) begin
            r_out_id       <= r_cur_id;
            r_out_switched <= r_res_switched;
            r_out_none     <= r_res_none;
            r_out_retired  <= r_res_retired;
            r_out_full     <= r_res_full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_running_id = r_out_id;
    assign o_switched   = r_out_switched;
    assign o_none_ready = r_out_none;
    assign o_retired    = r_out_retired;
    assign o_table_full = r_out_full;

`ifndef SYNTHESIS
    // Thread count stays between one and the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_THREADS)))
        else $error("thread count out of range");

    // Running slot always lies inside the filled part of the table
    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_cur) < r_count)
        else $error("running slot beyond thread count");

    // Main id belongs to slot 0 and to no other slot
    a_main_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == '0) == (r_cur_id == tts_pkg::MAIN_ID))
        else $error("running id does not match running slot");

    // A finished result waits while the output beat is stalled
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tts_pkg::ST_DONE && r_out_valid && !i_out_ready) |=> (r_st == tts_pkg::ST_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

[test/sched_result_check.sv]
// Result checker for the thread table scheduler: table predictor and beat comparison.
`timescale 1ns / 100ps

module sched_result_check #(
    parameter int MAX_THREADS = tts_pkg::MAX_THREADS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Item channel
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [tts_pkg::CMD_W-1:0]        i_cmd,
    input  logic [tts_pkg::TID_W-1:0]        i_thread_id,
    input  logic [tts_pkg::LIFE_W-1:0]       i_run_length,
    input  logic [tts_pkg::PRIO_W-1:0]       i_urgency,
    // Result channel
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [tts_pkg::ID_W-1:0]  i_running_id,
    input  logic                             i_switched,
    input  logic                             i_none_ready,
    input  logic                             i_retired,
    input  logic                             i_table_full,
    // Register write channel
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Status for the testbench top
    output int                               o_errors,
    output int                               o_pending
);
    import tts_pkg::*;

    typedef struct packed {
        logic signed [ID_W-1:0] run_id;
        logic                   switched;
        logic                   none_rdy;
        logic                   retired;
        logic                   full;
    } t_outcome;

    // Shadow copy of the thread table and the policy
    logic [POL_W-1:0]       pol;
    logic signed [ID_W-1:0] tid_tab  [MAX_THREADS];
    logic [LIFE_W-1:0]      life_tab [MAX_THREADS];
    logic [PRIO_W-1:0]      prio_tab [MAX_THREADS];
    bit                     dead_tab [MAX_THREADS];
    int unsigned            n_threads;
    int unsigned            cur;

    t_outcome outcome_q[$];
    int       err_cnt = 0;

    // Apply one item to the shadow table and return the result it yields
    function automatic t_outcome schedule_item(input logic [CMD_W-1:0] cmd,
                                               input logic [TID_W-1:0] tid,
                                               input logic [LIFE_W-1:0] len,
                                               input logic [PRIO_W-1:0] urg);
        t_outcome    res;
        int unsigned prev, nxt, s, k;
        bit          found, rotate;
        res = '0;
        rotate = (pol == POL_FIFO) || (pol == POL_RR);
        case (cmd)
            CMD_CREATE: begin
                if (n_threads >= MAX_THREADS) begin
                    res.full = 1'b1;
                end else begin
                    tid_tab[n_threads]  = $signed({1'b0, tid});
                    life_tab[n_threads] = len;
                    prio_tab[n_threads] = urg;
                    dead_tab[n_threads] = 1'b0;
                    n_threads++;
                end
            end
            CMD_TICK: begin
                if (n_threads <= 1) begin
                    res.none_rdy = 1'b1;
                end else begin
                    prev  = cur;
                    nxt   = prev;
                    found = 1'b0;
                    if (rotate) begin
                        // walk forward in creation order, wrap to slot 0
                        s = prev;
                        for (k = 1; k < n_threads; k++) begin
                            s = (s + 1 < n_threads) ? s + 1 : 0;
                            if (!found && !dead_tab[s]) begin
                                nxt   = s;
                                found = 1'b1;
                            end
                        end
                    end else begin
                        // best live entry with another id, oldest wins ties
                        for (k = 0; k < n_threads; k++) begin
                            if (!dead_tab[k] && tid_tab[k] != tid_tab[prev]) begin
                                if (!found) begin
                                    nxt   = k;
                                    found = 1'b1;
                                end else if (pol == POL_SJF) begin
                                    if (life_tab[k] < life_tab[nxt]) nxt = k;
                                end else if (prio_tab[k] > prio_tab[nxt]) begin
                                    nxt = k;
                                end
                            end
                        end
                    end
                    if (!found) res.none_rdy = 1'b1;
                    cur = nxt;
                    if (rotate)
                        res.switched = (tid_tab[prev] != MAIN_ID) || (tid_tab[nxt] != MAIN_ID);
                    else
                        res.switched = (tid_tab[prev] != tid_tab[nxt]);
                end
            end
            CMD_EXIT: begin
                if (pol == POL_FIFO || pol == POL_SJF) begin
                    dead_tab[cur] = 1'b1;
                    res.retired   = 1'b1;
                end else if (tid_tab[cur] != MAIN_ID) begin
                    // age the running thread, retire it at zero
                    life_tab[cur] = life_tab[cur] - 16'd1;
                    if (life_tab[cur] == '0) begin
                        dead_tab[cur] = 1'b1;
                        res.retired   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.run_id = tid_tab[cur];
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // Track beats on all three channels
    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            pol = POL_FIFO;
            for (int i = 0; i < MAX_THREADS; i++) begin
                tid_tab[i]  = '0;
                life_tab[i] = '0;
                prio_tab[i] = '0;
                dead_tab[i] = 1'b0;
            end
            tid_tab[0] = MAIN_ID;
            n_threads  = 1;
            cur        = 0;
            outcome_q.delete();
        end else begin
            // compare a result beat against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with nothing pending: running_id %0d", i_running_id);
                    err_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("running_id", want.run_id, i_running_id);
                    check_field("switched", want.switched, i_switched);
                    check_field("none_ready", want.none_rdy, i_none_ready);
                    check_field("retired", want.retired, i_retired);
                    check_field("table_full", want.full, i_table_full);
                end
            end
            // register writes; the main thread entry follows its registers at once
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POLICY:    pol = i_cfg_data[POL_W-1:0];
                    CFG_MAIN_LIFE: life_tab[0] = i_cfg_data[LIFE_W-1:0];
                    CFG_MAIN_PRIO: prio_tab[0] = i_cfg_data[PRIO_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(schedule_item(i_cmd, i_thread_id, i_run_length, i_urgency));
        end
        o_errors  <= err_cnt;
        o_pending <= outcome_q.size();
    end

endmodule

[test/thread_table_scheduler_tb.sv]
// Testbench top for the thread table scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module thread_table_scheduler_tb;
    import tts_pkg::*;

    localparam int NTHREADS     = MAX_THREADS_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 84;

    // Spare command code; the block reports the running id and changes nothing
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [CMD_W-1:0]       i_cmd;
    logic [TID_W-1:0]       i_thread_id;
    logic [LIFE_W-1:0]      i_run_length;
    logic [PRIO_W-1:0]      i_urgency;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [ID_W-1:0] o_running_id;
    logic                   o_switched;
    logic                   o_none_ready;
    logic                   o_retired;
    logic                   o_table_full;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int chk_errors;
    int chk_pending;
    int idle_cycles = 0;
    int table_used  = 1;
    int steady_left = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    thread_table_scheduler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_thread_id  (i_thread_id),
        .i_run_length (i_run_length),
        .i_urgency    (i_urgency),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_running_id (o_running_id),
        .o_switched   (o_switched),
        .o_none_ready (o_none_ready),
        .o_retired    (o_retired),
        .o_table_full (o_table_full),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    sched_result_check #(.MAX_THREADS(NTHREADS)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_thread_id  (i_thread_id),
        .i_run_length (i_run_length),
        .i_urgency    (i_urgency),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_running_id (o_running_id),
        .i_switched   (o_switched),
        .i_none_ready (o_none_ready),
        .i_retired    (o_retired),
        .i_table_full (o_table_full),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stop the run when no channel moves a beat for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random bursts and gaps, one long hold-off on request
    initial begin : drain_side
        int run_len;
        int gap_len;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            run_len = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30)
                                                  : $urandom_range(8, 1);
            i_out_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            gap_len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 15)
                                                  : $urandom_range(3, 1);
            i_out_ready <= 1'b0;
            repeat (gap_len) @(posedge i_clk);
        end
    end

    // Offer one item after a random gap and hold it until the beat is taken
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid,
                         input logic [LIFE_W-1:0] len, input logic [PRIO_W-1:0] urg);
        int gap_len;
        if (steady_left > 0) begin
            gap_len = 0;
            steady_left--;
        end else if ($urandom_range(39, 0) == 0) begin
            gap_len     = 0;
            steady_left = 30;
        end else if ($urandom_range(1, 0) == 0) begin
            gap_len = 0;
        end else begin
            gap_len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10)
                                                  : $urandom_range(3, 1);
        end
        if (gap_len > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap_len) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_thread_id  <= tid;
        i_run_length <= len;
        i_urgency    <= urg;
        if (cmd == CMD_CREATE && table_used < NTHREADS) table_used++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic quiesce;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                ph;
        int                done_here;
        int                roll;
        int                exit_rate;
        int                make_rate;
        bit                ignored;
        logic [POL_W-1:0]  pol;
        logic [CMD_W-1:0]  cmd;
        logic [TID_W-1:0]  tid;
        logic [LIFE_W-1:0] len;
        logic [PRIO_W-1:0] urg;
        logic [LIFE_W-1:0] main_life;
        logic [PRIO_W-1:0] main_prio;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= CMD_CREATE;
        i_thread_id  <= '0;
        i_run_length <= '0;
        i_urgency    <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_POLICY;
        i_cfg_data   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: lone main thread, spare command
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_SPARE, 8'hFF, 16'hFFFF, 8'hFF);

        // Priority with extreme main entry; main exit is a no-op
        quiesce();
        write_reg(CFG_POLICY, {14'd0, POL_PRIO});
        write_reg(CFG_MAIN_LIFE, 16'hFFFF);
        write_reg(CFG_MAIN_PRIO, 16'h00FF);
        i_cfg_valid <= 1'b0;
        offer(CMD_EXIT, 8'd0, 16'd0, 8'd0);
        offer(CMD_CREATE, 8'd0, 16'd0, 8'd0);
        offer(CMD_CREATE, 8'd255, 16'hFFFF, 8'd255);
        offer(CMD_CREATE, 8'd255, 16'd1, 8'd255);
        offer(CMD_CREATE, 8'd7, 16'd2, 8'd200);
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_EXIT, 8'd0, 16'd0, 8'd0);

        // Round robin: zero lifetime wraps, lifetime one retires, wrap to main
        quiesce();
        write_reg(CFG_POLICY, {14'd0, POL_RR});
        i_cfg_valid <= 1'b0;
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_EXIT, 8'd0, 16'd0, 8'd0);
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_EXIT, 8'd0, 16'd0, 8'd0);
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);

        // Shortest job with a zero main lifetime; repeated exit
        quiesce();
        write_reg(CFG_POLICY, {14'd0, POL_SJF});
        write_reg(CFG_MAIN_LIFE, 16'h0000);
        write_reg(CFG_MAIN_PRIO, 16'h0000);
        i_cfg_valid <= 1'b0;
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);
        offer(CMD_EXIT, 8'd0, 16'd0, 8'd0);
        offer(CMD_EXIT, 8'd0, 16'd0, 8'd0);
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);

        // Back to FIFO
        quiesce();
        write_reg(CFG_POLICY, {14'd0, POL_FIFO});
        i_cfg_valid <= 1'b0;
        offer(CMD_TICK, 8'd0, 16'd0, 8'd0);

        // Random phases, one policy each, with fresh main entry values
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0:       pol = POL_RR;
                1:       pol = POL_PRIO;
                2:       pol = POL_SJF;
                default: pol = POL_FIFO;
            endcase
            main_life = (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hFFFF : 16'($urandom);
            main_prio = (ph == 1) ? 8'hFF : (ph == 2) ? 8'h00 : 8'($urandom);
            quiesce();
            write_reg(CFG_POLICY, {14'd0, pol});
            write_reg(CFG_MAIN_LIFE, main_life);
            write_reg(CFG_MAIN_PRIO, {8'd0, main_prio});
            i_cfg_valid <= 1'b0;
            // let the result side back up while items keep coming
            if (ph == 1) hold_req = 1'b1;

            // exits are rare where they kill, so the table stays populated
            exit_rate = (pol == POL_FIFO || pol == POL_SJF) ? 4 : 20;
            done_here = 0;
            while (done_here < PHASE_ITEMS) begin
                make_rate = (table_used < NTHREADS) ? 20 : 4;
                roll = $urandom_range(99, 0);
                if (roll < make_rate)
                    cmd = CMD_CREATE;
                else if (roll < make_rate + exit_rate)
                    cmd = CMD_EXIT;
                else if (roll < make_rate + exit_rate + 2)
                    cmd = CMD_SPARE;
                else
                    cmd = CMD_TICK;
                tid = ($urandom_range(2, 0) == 0) ? 8'($urandom_range(3, 0)) : 8'($urandom);
                case ($urandom_range(9, 0))
                    0:          len = 16'h0000;
                    1:          len = 16'hFFFF;
                    2, 3, 4, 5: len = 16'($urandom_range(4, 1));
                    default:    len = 16'($urandom);
                endcase
                urg = ($urandom_range(3, 0) == 0) ? 8'd128 : 8'($urandom);
                ignored = (cmd == CMD_SPARE) || (cmd == CMD_CREATE && table_used >= NTHREADS);
                offer(cmd, tid, len, urg);
                if (!ignored) done_here++;
            end
        end

        quiesce();
        if (chk_errors == 0 && chk_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
